>>> design/rce_pkg.sv
// package: shared constants, types and sequencer states of the range coder encoder
`default_nettype none

package rce_pkg;

  localparam int FREQ_BITS_DEF    = 16;
  localparam int PENDING_BITS_DEF = 32;

  localparam int RUN_BITS = 32;
  localparam int QUOT_BITS = 32;

  localparam logic [31:0] RENORM_LIMIT = 32'h0100_0000;
  localparam logic [31:0] CARRY_LIMIT  = 32'hFF00_0000;
  localparam logic [31:0] FULL_RANGE   = 32'hFFFF_FFFF;

  localparam logic [2:0] RENORM_SHIFTS = 3'd4;
  localparam logic [2:0] FLUSH_SHIFTS  = 3'd5;

  localparam logic [7:0] RUN_NO_CARRY = 8'hFF;
  localparam logic [7:0] RUN_CARRY    = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_LOW,
    ST_MUL_RANGE,
    ST_SET_RANGE,
    ST_SHIFT,
    ST_CLOSE
  } state_t;

  typedef struct packed {
    logic [7:0]          head_byte;
    logic [RUN_BITS-1:0] run_length;
    logic [7:0]          run_byte;
  } result_t;

  typedef struct packed {
    logic push;
    logic close;
  } res_ctl_t;

endpackage

`default_nettype wire

>>> design/rce_if.sv
// interfaces: symbol input channel and result output channel
`default_nettype none

interface rce_in_if import rce_pkg::*; #(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [FREQ_BITS-1:0] cum_freq;
  logic [FREQ_BITS-1:0] sym_freq;
  logic [FREQ_BITS:0]   total_freq;

  modport source (output valid, kind, cum_freq, sym_freq, total_freq, input ready);
  modport sink (input valid, kind, cum_freq, sym_freq, total_freq, output ready);
endinterface

interface rce_out_if import rce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [7:0]          head_byte;
  logic [RUN_BITS-1:0] run_length;
  logic [7:0]          run_byte;
  logic                last;

  modport source (output valid, head_byte, run_length, run_byte, last, input ready);
  modport sink (input valid, head_byte, run_length, run_byte, last, output ready);
endinterface

`default_nettype wire

>>> design/rce_div.sv
// iterative restoring divider: 32-bit range by the total, one quotient bit per cycle
`default_nettype none

module rce_div import rce_pkg::*; #(
  parameter int DIV_W = FREQ_BITS_DEF + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [QUOT_BITS-1:0] dividend,
  input  wire logic [DIV_W-1:0]     divisor,
  output logic                      done,
  output logic [QUOT_BITS-1:0]      quotient
);

  localparam int CW = $clog2(QUOT_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(QUOT_BITS - 1);

  logic             busy;
  logic [CW-1:0]    step;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W-1:0] rem;
  logic [QUOT_BITS-1:0] quo;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[QUOT_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
      quo <= {quo[QUOT_BITS-2:0], fits};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still iterating");
  a_rem_below: assert property (@(posedge clk) disable iff (rst) busy |-> rem < dvs)
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> design/rce_out.sv
// result stage: one held result plus the output register, marks the last result of an item
`default_nettype none

module rce_out import rce_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire res_ctl_t ctl,
  input  wire result_t  res,
  output logic          can_step,
  rce_out_if.source     results
);

  logic    hold_valid;
  result_t hold;
  logic    out_valid;
  result_t out_res;
  logic    out_last;
  logic    out_free;
  logic    move;

  assign out_free = !out_valid || results.ready;
  assign can_step = !hold_valid || out_free;
  assign move     = (ctl.push || ctl.close) && hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.push) begin
        hold_valid <= 1'b1;
      end else if (ctl.close) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      hold <= res;
    end
    if (move) begin
      out_res  <= hold;
      out_last <= ctl.close;
    end
  end

  assign results.valid      = out_valid;
  assign results.head_byte  = out_res.head_byte;
  assign results.run_length = out_res.run_length;
  assign results.run_byte   = out_res.run_byte;
  assign results.last       = out_last;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.push || ctl.close) |-> can_step)
    else $error("result stage overrun");
  a_push_close: assert property (@(posedge clk) disable iff (rst) !(ctl.push && ctl.close))
    else $error("push and close together");
  a_move_valid: assert property (@(posedge clk) disable iff (rst) move |=> out_valid)
    else $error("held result lost");

endmodule

`default_nettype wire

>>> design/range_coder_encoder.sv
// top level: range coder encoder with carry bit, cached byte and deferred 0xff run count
//
// symbols channel takes one item: kind 0 encodes a symbol (cum_freq, sym_freq,
// total_freq), kind 1 flushes the coder with five byte shifts. results channel
// gives one item per emitting byte shift: head_byte, then run_length bytes of
// run_byte; last marks the final result of an input item.
// ready is high only while the sequencer is idle. an encode takes a setup step,
// the bit-serial divider (one quotient bit per cycle), the shared multiplier and
// range update, up to 4 renormalize shifts plus a step to leave the shift loop,
// and a closing step. a flush takes its five byte shifts, the loop exit and the
// close. an invalid symbol is dropped in its accept cycle.
// reset (rst, synchronous) sets low 0, range 0xffffffff, carry, cached byte and
// pending count 0, and empties the result stage. when the receiver stalls, one
// result waits in the output register and one in a holding register; the
// sequencer waits on an emitting shift until room opens, and a new item can be
// accepted while the last result of the previous one still waits.
`default_nettype none

module range_coder_encoder import rce_pkg::*; #(
  parameter int FREQ_BITS    = FREQ_BITS_DEF,
  parameter int PENDING_BITS = PENDING_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  rce_in_if.sink    symbols,
  rce_out_if.source results
);

  localparam int TW = FREQ_BITS + 1;
  localparam int MW = FREQ_BITS + QUOT_BITS;

  state_t state, state_next;

  logic                    item_kind;
  logic [FREQ_BITS-1:0]    cum;
  logic [FREQ_BITS-1:0]    sym;
  logic [QUOT_BITS-1:0]    quot;
  logic [31:0]             prod;
  logic [2:0]              cnt;

  logic [31:0]             low_reg;
  logic [31:0]             range_reg;
  logic                    carry_bit;
  logic [7:0]              cached_byte;
  logic [PENDING_BITS-1:0] pending_count;

  logic                    accept;
  logic [TW-1:0]           freq_sum;
  logic                    item_ok;
  logic                    emit;
  logic                    shift_more;
  logic                    do_shift;
  logic                    div_start;
  logic                    div_done;
  logic [QUOT_BITS-1:0]    div_q;
  logic [FREQ_BITS-1:0]    mul_a;
  logic [MW-1:0]           mul_full;
  logic [32:0]             low_sum;
  logic                    can_step;
  res_ctl_t                ctl;
  result_t                 res;

  rce_div #(.DIV_W(TW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (range_reg),
    .divisor  (symbols.total_freq),
    .done     (div_done),
    .quotient (div_q)
  );

  rce_out u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .res      (res),
    .can_step (can_step),
    .results  (results)
  );

  assign accept   = symbols.valid && symbols.ready;
  assign freq_sum = {1'b0, symbols.cum_freq} + {1'b0, symbols.sym_freq};
  assign item_ok  = symbols.kind
                 || ((symbols.total_freq != '0) && (symbols.sym_freq != '0)
                     && !(freq_sum > symbols.total_freq)
                     && !(range_reg < 32'(symbols.total_freq)));

  assign emit       = (low_reg < CARRY_LIMIT) || carry_bit;
  assign shift_more = (cnt != '0) && (item_kind || (range_reg < RENORM_LIMIT));

  // shared multiplier: cum_freq * q, then sym_freq * q
  assign mul_a    = (state == ST_MUL_LOW) ? cum : sym;
  assign mul_full = MW'(mul_a) * MW'(quot);
  assign low_sum  = {1'b0, low_reg} + {1'b0, prod};

  assign res.head_byte  = cached_byte + 8'(carry_bit);
  assign res.run_length = RUN_BITS'(pending_count);
  assign res.run_byte   = carry_bit ? RUN_CARRY : RUN_NO_CARRY;

  always_comb begin
    state_next    = state;
    div_start     = 1'b0;
    do_shift      = 1'b0;
    ctl           = '0;
    symbols.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        symbols.ready = 1'b1;
        if (symbols.valid && item_ok) begin
          if (symbols.kind) begin
            state_next = ST_SHIFT;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL_LOW;
        end
      end
      ST_MUL_LOW:   state_next = ST_MUL_RANGE;
      ST_MUL_RANGE: state_next = ST_SET_RANGE;
      ST_SET_RANGE: state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (!shift_more) begin
          state_next = ST_CLOSE;
        end else if (!emit || can_step) begin
          do_shift = 1'b1;
          ctl.push = emit;
        end
      end
      ST_CLOSE: begin
        if (can_step) begin
          ctl.close  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      low_reg       <= '0;
      range_reg     <= FULL_RANGE;
      carry_bit     <= 1'b0;
      cached_byte   <= '0;
      pending_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= symbols.kind ? FLUSH_SHIFTS : RENORM_SHIFTS;
      end
      if (state == ST_MUL_RANGE) begin
        low_reg <= low_sum[31:0];
        if (low_sum[32]) begin
          carry_bit <= 1'b1;
        end
      end
      if (state == ST_SET_RANGE) begin
        range_reg <= prod;
      end
      if (do_shift) begin
        cnt     <= cnt - 1'b1;
        low_reg <= {low_reg[23:0], 8'h00};
        if (!item_kind) begin
          range_reg <= {range_reg[23:0], 8'h00};
        end
        if (emit) begin
          pending_count <= '0;
          cached_byte   <= low_reg[31:24];
          carry_bit     <= 1'b0;
        end else begin
          pending_count <= pending_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind <= symbols.kind;
      cum       <= symbols.cum_freq;
      sym       <= symbols.sym_freq;
    end
    if (state == ST_DIV && div_done) begin
      quot <= div_q;
    end
    if (state == ST_MUL_LOW || state == ST_MUL_RANGE) begin
      prod <= mul_full[31:0];
    end
  end

  a_range_norm: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> range_reg >= RENORM_LIMIT)
    else $error("range left below renormalize limit");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");
  a_shift_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> cnt <= FLUSH_SHIFTS)
    else $error("shift count out of range");
  a_close_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.close |=> state == ST_IDLE)
    else $error("close did not return to idle");

endmodule

`default_nettype wire
